// ----- design/m4m_pkg.sv -----
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// No dependencies; imported by the top level and the port checker.
package m4m_pkg;

  localparam int DATA_W    = 32;  // width of one Q16.16 element
  localparam int FRAC_BITS = 16;  // fraction bits dropped after the sum
  localparam int S_TDATA_W = 2 * DATA_W;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_ISSUE = 3'b010,
    S_WAIT  = 3'b100
  } state_t;

endpackage

// ----- design/m4m_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module m4m_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/matrix4_multiply.sv -----
// Load: one element pair per cycle while s_tready is high; tlast starts the product.
// Each result element goes through the single multiply-accumulate path
// (DIM paired reads from the two stores, then multiply, accumulate, saturate);
// the next element's reads start only after the last element's sum is done.
// Synchronous reset clears the load position, the sequencer and the output
// valid; stores are not cleared.
// Depends on m4m_pkg and m4m_ram.
module matrix4_multiply import m4m_pkg::*; #(
  parameter int DIM = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // a_elem [31:0], b_elem [63:32]
  input  logic                 s_tlast,   // load_last
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_W-1:0]    m_tdata,   // c_elem [31:0]
  output logic                 m_tuser,   // saturated [0]
  output logic                 m_tlast    // out_last
);

  localparam int NELEM = DIM * DIM;
  localparam int IDX_W = $clog2(NELEM);
  localparam int DIM_W = $clog2(DIM);
  localparam int ACC_W = 2 * DATA_W + $clog2(DIM);
  localparam int HI_LSB = FRAC_BITS + DATA_W - 1;

  state_t state;
  logic [IDX_W-1:0] load_index;
  logic [DIM_W-1:0] row, col, k;

  logic in_beat, out_free, issuing, k_end;
  logic [IDX_W-1:0] a_rd_addr, b_rd_addr;
  logic [DATA_W-1:0] a_rd_data, b_rd_data;

  logic v1, v1_first, v1_last, v1_elast;
  logic v2, v2_first, v2_last, v2_elast;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [ACC_W-1:0] acc, prod_ext;
  logic done, done_elast;

  logic [ACC_W-1-HI_LSB:0] acc_hi;
  logic fits;
  logic [DATA_W-1:0] sat_value;

  assign s_tready = (state == S_LOAD);
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign k_end    = (k == DIM_W'(DIM - 1));
  // Only one element is in flight, so a free output slot at the first read
  // stays free until its result lands.
  assign issuing  = (state == S_ISSUE) && ((k != '0) || out_free);

  assign a_rd_addr = IDX_W'(row * DIM + k);
  assign b_rd_addr = IDX_W'(k * DIM + col);

  m4m_ram #(.WIDTH(DATA_W), .DEPTH(NELEM)) u_store_a (
    .clk     (clk),
    .wr_en   (in_beat),
    .wr_addr (load_index),
    .wr_data (s_tdata[DATA_W-1:0]),
    .rd_en   (issuing),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd_data)
  );

  m4m_ram #(.WIDTH(DATA_W), .DEPTH(NELEM)) u_store_b (
    .clk     (clk),
    .wr_en   (in_beat),
    .wr_addr (load_index),
    .wr_data (s_tdata[S_TDATA_W-1:DATA_W]),
    .rd_en   (issuing),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data)
  );

  // Sequencer: load position, element and term counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_index <= '0;
      row        <= '0;
      col        <= '0;
      k          <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_beat) begin
            if (s_tlast) begin
              load_index <= '0;
              state      <= S_ISSUE;
            end else if (load_index == IDX_W'(NELEM - 1)) begin
              load_index <= '0;
            end else begin
              load_index <= load_index + 1'b1;
            end
          end
        end
        S_ISSUE: begin
          if (issuing) begin
            if (k_end) begin
              k     <= '0;
              state <= S_WAIT;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        S_WAIT: begin
          if (done) begin
            if (col == DIM_W'(DIM - 1)) begin
              col <= '0;
              row <= (row == DIM_W'(DIM - 1)) ? '0 : row + 1'b1;
            end else begin
              col <= col + 1'b1;
            end
            state <= done_elast ? S_LOAD : S_ISSUE;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Read, multiply and accumulate stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= issuing;
      v2   <= v1;
      done <= v2 && v2_last;
    end
  end

  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    v1_first   <= (k == '0);
    v1_last    <= k_end;
    v1_elast   <= (row == DIM_W'(DIM - 1)) && (col == DIM_W'(DIM - 1));
    v2_first   <= v1_first;
    v2_last    <= v1_last;
    v2_elast   <= v1_elast;
    prod       <= (2*DATA_W)'($signed(a_rd_data)) * (2*DATA_W)'($signed(b_rd_data));
    done_elast <= v2_elast;
    if (v2) begin
      acc <= v2_first ? prod_ext : acc + prod_ext;
    end
  end

  // The sum fits when every bit above the kept field equals the sign.
  assign acc_hi    = acc[ACC_W-1:HI_LSB];
  assign fits      = (&acc_hi) || !(|acc_hi);
  assign sat_value = acc[ACC_W-1] ? SAT_MIN : SAT_MAX;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= fits ? acc[HI_LSB:FRAC_BITS] : sat_value;
      m_tuser <= !fits;
      m_tlast <= done_elast;
    end
  end

endmodule

// ----- design/m4m_checker.sv -----
// Port-level checks for the matrix multiplier, bound to the top level.
// Depends on m4m_pkg.
module m4m_checker import m4m_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 s_tlast,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [DATA_W-1:0]    m_tdata,
  input logic                 m_tuser,
  input logic                 m_tlast
);

  // A tlast beat starts the product, so loading stops right after it.
  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input still accepted after a tlast beat");

  // A clipped element carries one of the two limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == SAT_MAX) || (m_tdata == SAT_MIN))
    else $error("saturated beat without a limit value");

  // Reset empties the output register.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

endmodule

bind matrix4_multiply m4m_checker u_checker (.*);
